// File: rtl/core/fbrb_pkg.sv
// shared types, constants and helpers for the frame buffer reduce and blend engine
package fbrb_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int X_W        = $clog2(MAX_WIDTH);
	localparam int Y_W        = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = X_W + Y_W;

	localparam int STORE_W    = 32;
	localparam int COORD_W    = 16;
	localparam int CLIP_W     = COORD_W + 1;
	localparam int DIM_W      = 9;
	localparam int FUNC_W     = 3;
	localparam int OP_W       = 2;
	localparam int SEG_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int ALPHA_W    = 17;
	localparam int Q_FRAC     = 16;
	localparam int IA_W       = ALPHA_W + 1;
	localparam int AV_W       = ALPHA_W + STORE_W;
	localparam int PROD_W     = IA_W + STORE_W;
	localparam int MIX_W      = PROD_W + 1;
	localparam int SUM_W      = STORE_W + 2;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
	localparam logic signed [STORE_W-1:0] STORE_MAX = {1'b0, {(STORE_W-1){1'b1}}};
	localparam logic signed [STORE_W-1:0] STORE_MIN = {1'b1, {(STORE_W-1){1'b0}}};

	localparam logic [FUNC_W-1:0] FN_POINT   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_BOX     = 3'd1;
	localparam logic [FUNC_W-1:0] FN_OUTLINE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

	localparam logic [OP_W-1:0] OP_MIN = 2'd0;
	localparam logic [OP_W-1:0] OP_MAX = 2'd1;
	localparam logic [OP_W-1:0] OP_SUM = 2'd2;
	localparam logic [OP_W-1:0] OP_SET = 2'd3;

	localparam logic [SEG_W-1:0] SEG_ROW_LO = 2'd0;
	localparam logic [SEG_W-1:0] SEG_ROW_HI = 2'd1;
	localparam logic [SEG_W-1:0] SEG_COL_LO = 2'd2;
	localparam logic [SEG_W-1:0] SEG_COL_HI = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OP     = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [COORD_W-1:0] x_lo;
		logic signed [COORD_W-1:0] x_hi;
		logic signed [COORD_W-1:0] y_lo;
		logic signed [COORD_W-1:0] y_hi;
		logic signed [STORE_W-1:0] value_in;
		logic [ALPHA_W-1:0]        alpha;
		logic [OP_W-1:0]           outline_op;
	} req_t;

	typedef struct packed {
		logic signed [STORE_W-1:0] pixel_value;
		logic                      alpha_out_of_range;
	} rsp_t;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [OP_W-1:0]  reduce_op;
	} cfg_t;

	typedef struct packed {
		logic                      rd_en;
		logic [ADDR_W-1:0]         rd_addr;
		logic                      wr_en;
		logic [ADDR_W-1:0]         wr_addr;
		logic signed [STORE_W-1:0] wr_data;
	} ram_ctl_t;

	typedef struct packed {
		logic            load;
		logic            capture;
		logic [OP_W-1:0] op;
	} blend_ctl_t;

	typedef struct packed {
		logic valid;
		rsp_t rsp;
	} fin_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEG,
		ST_RD,
		ST_MUL,
		ST_WR,
		ST_CLR,
		ST_DONE
	} state_t;

	function automatic logic signed [STORE_W-1:0] sat_store(input logic signed [MIX_W-1:0] v);
		logic fits;
		fits = (&v[MIX_W-1:STORE_W-1]) || ~(|v[MIX_W-1:STORE_W-1]);
		if (fits) begin
			sat_store = v[STORE_W-1:0];
		end else if (v[MIX_W-1]) begin
			sat_store = STORE_MIN;
		end else begin
			sat_store = STORE_MAX;
		end
	endfunction

endpackage

// File: rtl/core/framebuffer_reduce_blend_engine.sv
// top level: configuration registers, response register, sequencer, blend datapath and pixel store
// Each request returns exactly one response. Points, filled boxes and outlines are paced by the
// read, multiply, write-back loop around the single pixel memory, which finishes one pixel before
// reading the next so repeated pixels such as outline corners always see their own update; a read
// stops after the read and multiply steps. A clear writes all 65536 pixels at one per cycle.
// Pixel contents are undefined after reset until the first clear. A new request is taken as soon
// as the previous one has handed its response to the output register, even while that response
// still waits to be taken.
module framebuffer_reduce_blend_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  fbrb_pkg::req_t                       req_data,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output fbrb_pkg::rsp_t                       rsp_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fbrb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fbrb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	fbrb_pkg::cfg_t       cfg_q;
	fbrb_pkg::ram_ctl_t   ram;
	fbrb_pkg::blend_ctl_t bctl;
	fbrb_pkg::fin_t       fin;
	fbrb_pkg::rsp_t       rsp_q;
	logic                 rsp_valid_q;
	logic                 fin_take;
	logic [fbrb_pkg::STORE_W-1:0]        rd_raw;
	logic signed [fbrb_pkg::STORE_W-1:0] new_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= fbrb_pkg::DIM_W'(256);
			cfg_q.image_height <= fbrb_pkg::DIM_W'(256);
			cfg_q.reduce_op    <= fbrb_pkg::OP_SUM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fbrb_pkg::CFG_WIDTH:  cfg_q.image_width  <= cfg_data;
				fbrb_pkg::CFG_HEIGHT: cfg_q.image_height <= cfg_data;
				fbrb_pkg::CFG_OP:     cfg_q.reduce_op    <= cfg_data[fbrb_pkg::OP_W-1:0];
				default:              cfg_q.reduce_op    <= cfg_q.reduce_op;
			endcase
		end
	end

	// response register parts the sequencer from the response channel
	assign fin_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin.valid && fin_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid && fin_take) begin
			rsp_q <= fin.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	fbrb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.cfg       (cfg_q),
		.rd_data   ($signed(rd_raw)),
		.new_value (new_value),
		.ram       (ram),
		.bctl      (bctl),
		.fin       (fin),
		.fin_take  (fin_take)
	);

	fbrb_blend u_blend (
		.clk       (clk),
		.ctl       (bctl),
		.alpha     (req_data.alpha),
		.value_in  (req_data.value_in),
		.rd_data   ($signed(rd_raw)),
		.new_value (new_value)
	);

	fbrb_pixel_ram #(
		.ADDR_W (fbrb_pkg::ADDR_W),
		.DATA_W (fbrb_pkg::STORE_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram.wr_en),
		.wr_addr (ram.wr_addr),
		.wr_data (ram.wr_data),
		.rd_en   (ram.rd_en),
		.rd_addr (ram.rd_addr),
		.rd_data (rd_raw)
	);

endmodule

// File: rtl/core/fbrb_pixel_ram.sv
// pixel store: one write port, one read port with registered read data
module fbrb_pixel_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/fbrb_blend.sv
// blend datapath: weighted mix of value and pixel for min, max, set; sum adds scaled value
module fbrb_blend (
	input  logic                               clk,
	input  fbrb_pkg::blend_ctl_t               ctl,
	input  logic [fbrb_pkg::ALPHA_W-1:0]       alpha,
	input  logic signed [fbrb_pkg::STORE_W-1:0] value_in,
	input  logic signed [fbrb_pkg::STORE_W-1:0] rd_data,
	output logic signed [fbrb_pkg::STORE_W-1:0] new_value
);

	logic signed [fbrb_pkg::AV_W-1:0]    av_q;
	logic signed [fbrb_pkg::IA_W-1:0]    ia_q;
	logic signed [fbrb_pkg::PROD_W-1:0]  prod_s2;
	logic signed [fbrb_pkg::STORE_W-1:0] d_s2;

	logic signed [fbrb_pkg::PROD_W-1:0]  av_full;
	logic signed [fbrb_pkg::IA_W-1:0]    alpha_s;
	logic signed [fbrb_pkg::MIX_W-1:0]   mix;
	logic signed [fbrb_pkg::MIX_W-1:0]   mix_sh;
	logic [fbrb_pkg::SUM_W-1:0]          sum_raw;
	logic signed [fbrb_pkg::MIX_W-1:0]   sum_ext;
	logic signed [fbrb_pkg::STORE_W-1:0] blend_sat;
	logic signed [fbrb_pkg::STORE_W-1:0] sum_sat;

	assign alpha_s = $signed({1'b0, alpha});
	assign av_full = alpha_s * value_in;

	// operands fixed for the whole request
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			av_q <= av_full[fbrb_pkg::AV_W-1:0];
			ia_q <= fbrb_pkg::IA_W'(65536) - alpha_s;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			prod_s2 <= ia_q * rd_data;
			d_s2    <= rd_data;
		end
	end

	assign mix    = {{2{av_q[fbrb_pkg::AV_W-1]}}, av_q} + {prod_s2[fbrb_pkg::PROD_W-1], prod_s2};
	assign mix_sh = mix >>> fbrb_pkg::Q_FRAC;

	assign sum_raw = {{2{d_s2[fbrb_pkg::STORE_W-1]}}, d_s2}
		+ {av_q[fbrb_pkg::AV_W-1], av_q[fbrb_pkg::AV_W-1:fbrb_pkg::Q_FRAC]};
	assign sum_ext = {{(fbrb_pkg::MIX_W-fbrb_pkg::SUM_W){sum_raw[fbrb_pkg::SUM_W-1]}}, sum_raw};

	assign blend_sat = fbrb_pkg::sat_store(mix_sh);
	assign sum_sat   = fbrb_pkg::sat_store(sum_ext);

	always_comb begin
		case (ctl.op)
			fbrb_pkg::OP_MIN: new_value = (blend_sat < d_s2) ? blend_sat : d_s2;
			fbrb_pkg::OP_MAX: new_value = (blend_sat > d_s2) ? blend_sat : d_s2;
			fbrb_pkg::OP_SUM: new_value = sum_sat;
			fbrb_pkg::OP_SET: new_value = blend_sat;
			default:          new_value = blend_sat;
		endcase
	end

endmodule

// File: rtl/core/fbrb_seq.sv
// command sequencer: clips segments, walks pixels, drives read-modify-write and clear sweeps
module fbrb_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  fbrb_pkg::req_t                      req_data,
	input  fbrb_pkg::cfg_t                      cfg,
	input  logic signed [fbrb_pkg::STORE_W-1:0] rd_data,
	input  logic signed [fbrb_pkg::STORE_W-1:0] new_value,
	output fbrb_pkg::ram_ctl_t                  ram,
	output fbrb_pkg::blend_ctl_t                bctl,
	output fbrb_pkg::fin_t                      fin,
	input  logic                                fin_take
);

	fbrb_pkg::state_t state_q, state_d;

	logic [fbrb_pkg::FUNC_W-1:0]         func_q;
	logic signed [fbrb_pkg::COORD_W-1:0] xl_q, xh_q, yl_q, yh_q;
	logic [fbrb_pkg::OP_W-1:0]           op_q;
	logic                                flag_q;
	logic signed [fbrb_pkg::STORE_W-1:0] pix_q;
	logic signed [fbrb_pkg::STORE_W-1:0] fill_q;
	logic [fbrb_pkg::SEG_W-1:0]          seg_q;
	logic [fbrb_pkg::X_W-1:0]            x_q, xs_q, xe_q;
	logic [fbrb_pkg::Y_W-1:0]            y_q, ye_q;
	logic [fbrb_pkg::ADDR_W-1:0]         clr_q;

	logic signed [fbrb_pkg::COORD_W-1:0] xa, xb, ya, yb;
	logic signed [fbrb_pkg::COORD_W-1:0] xmin, xmax, ymin, ymax;
	logic signed [fbrb_pkg::CLIP_W-1:0]  xa_e, xb_e, ya_e, yb_e;
	logic signed [fbrb_pkg::CLIP_W-1:0]  xlo, xhi, ylo, yhi, wlim, hlim;
	logic [fbrb_pkg::DIM_W-1:0]          weff, heff;
	logic                                seg_empty, seg_last, row_end, seg_end;
	logic [fbrb_pkg::ADDR_W-1:0]         pix_addr;
	logic signed [fbrb_pkg::STORE_W-1:0] fill_d;

	assign xmin = (xl_q < xh_q) ? xl_q : xh_q;
	assign xmax = (xl_q < xh_q) ? xh_q : xl_q;
	assign ymin = (yl_q < yh_q) ? yl_q : yh_q;
	assign ymax = (yl_q < yh_q) ? yh_q : yl_q;

	// segment bounds before clipping
	always_comb begin
		xa = xl_q;
		xb = xl_q;
		ya = yl_q;
		yb = yl_q;
		case (func_q)
			fbrb_pkg::FN_BOX: begin
				xb = xh_q;
				yb = yh_q;
			end
			fbrb_pkg::FN_OUTLINE: begin
				case (seg_q)
					fbrb_pkg::SEG_ROW_LO: begin
						xa = xmin;
						xb = xmax;
					end
					fbrb_pkg::SEG_ROW_HI: begin
						xa = xmin;
						xb = xmax;
						ya = yh_q;
						yb = yh_q;
					end
					fbrb_pkg::SEG_COL_LO: begin
						ya = ymin;
						yb = ymax;
					end
					fbrb_pkg::SEG_COL_HI: begin
						xa = xh_q;
						xb = xh_q;
						ya = ymin;
						yb = ymax;
					end
					default: begin
						xa = xl_q;
					end
				endcase
			end
			default: begin
				xa = xl_q;
			end
		endcase
	end

	assign weff = (cfg.image_width > fbrb_pkg::DIM_W'(fbrb_pkg::MAX_WIDTH))
		? fbrb_pkg::DIM_W'(fbrb_pkg::MAX_WIDTH) : cfg.image_width;
	assign heff = (cfg.image_height > fbrb_pkg::DIM_W'(fbrb_pkg::MAX_HEIGHT))
		? fbrb_pkg::DIM_W'(fbrb_pkg::MAX_HEIGHT) : cfg.image_height;
	assign wlim = fbrb_pkg::CLIP_W'(weff) - fbrb_pkg::CLIP_W'(1);
	assign hlim = fbrb_pkg::CLIP_W'(heff) - fbrb_pkg::CLIP_W'(1);

	assign xa_e = {xa[fbrb_pkg::COORD_W-1], xa};
	assign xb_e = {xb[fbrb_pkg::COORD_W-1], xb};
	assign ya_e = {ya[fbrb_pkg::COORD_W-1], ya};
	assign yb_e = {yb[fbrb_pkg::COORD_W-1], yb};

	assign xlo = xa_e[fbrb_pkg::CLIP_W-1] ? '0 : xa_e;
	assign ylo = ya_e[fbrb_pkg::CLIP_W-1] ? '0 : ya_e;
	assign xhi = (xb_e > wlim) ? wlim : xb_e;
	assign yhi = (yb_e > hlim) ? hlim : yb_e;

	assign seg_empty = (xlo > xhi) || (ylo > yhi);
	assign seg_last  = (func_q != fbrb_pkg::FN_OUTLINE) || (seg_q == fbrb_pkg::SEG_COL_HI);
	assign row_end   = (x_q == xe_q);
	assign seg_end   = row_end && (y_q == ye_q);
	assign pix_addr  = {y_q, x_q};

	always_comb begin
		case (cfg.reduce_op)
			fbrb_pkg::OP_MIN: fill_d = fbrb_pkg::STORE_MAX;
			fbrb_pkg::OP_MAX: fill_d = fbrb_pkg::STORE_MIN;
			default:          fill_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d                     = state_q;
		req_stall                   = 1'b1;
		ram.rd_en                   = 1'b0;
		ram.rd_addr                 = pix_addr;
		ram.wr_en                   = 1'b0;
		ram.wr_addr                 = pix_addr;
		ram.wr_data                 = new_value;
		bctl.load                   = 1'b0;
		bctl.capture                = 1'b0;
		bctl.op                     = op_q;
		fin.valid                   = 1'b0;
		fin.rsp.pixel_value         = pix_q;
		fin.rsp.alpha_out_of_range  = flag_q;
		case (state_q)
			fbrb_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				bctl.load = req_valid;
				if (req_valid) begin
					case (req_data.func)
						fbrb_pkg::FN_POINT,
						fbrb_pkg::FN_BOX,
						fbrb_pkg::FN_OUTLINE,
						fbrb_pkg::FN_READ:  state_d = fbrb_pkg::ST_SEG;
						fbrb_pkg::FN_CLEAR: state_d = fbrb_pkg::ST_CLR;
						default:            state_d = fbrb_pkg::ST_DONE;
					endcase
				end
			end
			fbrb_pkg::ST_SEG: begin
				if (!seg_empty) begin
					state_d = fbrb_pkg::ST_RD;
				end else if (seg_last) begin
					state_d = fbrb_pkg::ST_DONE;
				end
			end
			fbrb_pkg::ST_RD: begin
				ram.rd_en = 1'b1;
				state_d   = fbrb_pkg::ST_MUL;
			end
			fbrb_pkg::ST_MUL: begin
				bctl.capture = 1'b1;
				state_d = (func_q == fbrb_pkg::FN_READ) ? fbrb_pkg::ST_DONE : fbrb_pkg::ST_WR;
			end
			fbrb_pkg::ST_WR: begin
				ram.wr_en = 1'b1;
				if (!seg_end) begin
					state_d = fbrb_pkg::ST_RD;
				end else if (seg_last) begin
					state_d = fbrb_pkg::ST_DONE;
				end else begin
					state_d = fbrb_pkg::ST_SEG;
				end
			end
			fbrb_pkg::ST_CLR: begin
				ram.wr_en   = 1'b1;
				ram.wr_addr = clr_q;
				ram.wr_data = fill_q;
				if (&clr_q) begin
					state_d = fbrb_pkg::ST_DONE;
				end
			end
			fbrb_pkg::ST_DONE: begin
				fin.valid = 1'b1;
				if (fin_take) begin
					state_d = fbrb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fbrb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fbrb_pkg::ST_IDLE: begin
				if (req_valid) begin
					func_q <= req_data.func;
					xl_q   <= req_data.x_lo;
					xh_q   <= req_data.x_hi;
					yl_q   <= req_data.y_lo;
					yh_q   <= req_data.y_hi;
					op_q   <= (req_data.func == fbrb_pkg::FN_OUTLINE)
						? req_data.outline_op : cfg.reduce_op;
					flag_q <= (req_data.func <= fbrb_pkg::FN_OUTLINE)
						&& (req_data.alpha > fbrb_pkg::ALPHA_ONE);
					pix_q  <= '0;
					fill_q <= fill_d;
					seg_q  <= fbrb_pkg::SEG_ROW_LO;
					clr_q  <= '0;
				end
			end
			fbrb_pkg::ST_SEG: begin
				if (seg_empty) begin
					seg_q <= seg_q + 1'b1;
				end else begin
					x_q  <= xlo[fbrb_pkg::X_W-1:0];
					xs_q <= xlo[fbrb_pkg::X_W-1:0];
					xe_q <= xhi[fbrb_pkg::X_W-1:0];
					y_q  <= ylo[fbrb_pkg::Y_W-1:0];
					ye_q <= yhi[fbrb_pkg::Y_W-1:0];
				end
			end
			fbrb_pkg::ST_MUL: begin
				if (func_q == fbrb_pkg::FN_READ) begin
					pix_q <= rd_data;
				end
			end
			fbrb_pkg::ST_WR: begin
				if (seg_end) begin
					seg_q <= seg_q + 1'b1;
				end else if (row_end) begin
					y_q <= y_q + 1'b1;
					x_q <= xs_q;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			fbrb_pkg::ST_CLR: begin
				clr_q <= clr_q + 1'b1;
			end
			default: begin
				clr_q <= clr_q;
			end
		endcase
	end

endmodule

// File: rtl/core/fbrb_checker.sv
// port-level checks for the frame buffer reduce and blend engine
module fbrb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  fbrb_pkg::req_t                  req_data,
	input  logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  fbrb_pkg::rsp_t                  rsp_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fbrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbrb_pkg::CFG_DATA_W-1:0] cfg_data
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	// one request at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// a new response is only loaded while the sequencer is busy
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without a request in flight");

	// flag and read data never come from the same request
	a_flag_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.alpha_out_of_range |-> rsp_data.pixel_value == '0)
		else $error("flagged response carries pixel data");

endmodule

bind framebuffer_reduce_blend_engine fbrb_checker u_fbrb_checker (.*);

// File: test/tb_framebuffer_reduce_blend_engine.sv
// testbench for the frame buffer reduce and blend engine, checked against a shadow copy of the image
module tb_framebuffer_reduce_blend_engine;
	import fbrb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;

	class framebuffer_shadow;
		logic signed [STORE_W-1:0] pixels [MAX_WIDTH*MAX_HEIGHT];
		int unsigned width_reg;
		int unsigned height_reg;
		logic [OP_W-1:0] op_reg;
		rsp_t expected_pixels[$];
		int mismatches;

		function new();
			foreach (pixels[i]) begin
				pixels[i] = '0;
			end
			width_reg = 256;
			height_reg = 256;
			op_reg = OP_SUM;
			mismatches = 0;
		endfunction

		function int eff_width();
			return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		endfunction

		function int eff_height();
			return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_WIDTH: width_reg = 32'(data);
				CFG_HEIGHT: height_reg = 32'(data);
				CFG_OP: op_reg = data[OP_W-1:0];
				default: ;
			endcase
		endfunction

		function longint sat_store32(longint x);
			if (x > longint'(STORE_MAX)) begin
				return longint'(STORE_MAX);
			end
			if (x < longint'(STORE_MIN)) begin
				return longint'(STORE_MIN);
			end
			return x;
		endfunction

		function void reduce_at(int x, int y, logic [OP_W-1:0] op, longint v, longint a);
			int idx;
			longint d;
			longint b;
			if (x < 0 || x >= eff_width() || y < 0 || y >= eff_height()) begin
				return;
			end
			idx = y * MAX_WIDTH + x;
			d = longint'(pixels[idx]);
			if (op == OP_SUM) begin
				pixels[idx] = STORE_W'(sat_store32(d + ((a * v) >>> Q_FRAC)));
				return;
			end
			b = sat_store32((a * v + (longint'(65536) - a) * d) >>> Q_FRAC);
			case (op)
				OP_MIN: pixels[idx] = STORE_W'((b < d) ? b : d);
				OP_MAX: pixels[idx] = STORE_W'((b > d) ? b : d);
				default: pixels[idx] = STORE_W'(b);
			endcase
		endfunction

		function void reduce_row(int x0, int x1, int y, logic [OP_W-1:0] op, longint v,
				longint a);
			int lo;
			int hi;
			lo = (x0 < 0) ? 0 : x0;
			hi = (x1 > eff_width() - 1) ? eff_width() - 1 : x1;
			for (int x = lo; x <= hi; x++) begin
				reduce_at(x, y, op, v, a);
			end
		endfunction

		function void reduce_col(int x, int y0, int y1, logic [OP_W-1:0] op, longint v,
				longint a);
			int lo;
			int hi;
			lo = (y0 < 0) ? 0 : y0;
			hi = (y1 > eff_height() - 1) ? eff_height() - 1 : y1;
			for (int y = lo; y <= hi; y++) begin
				reduce_at(x, y, op, v, a);
			end
		endfunction

		function void accept_command(req_t r);
			int xl;
			int xh;
			int yl;
			int yh;
			int lo;
			int hi;
			longint v;
			longint a;
			rsp_t want;
			logic signed [STORE_W-1:0] fill;
			xl = int'(r.x_lo);
			xh = int'(r.x_hi);
			yl = int'(r.y_lo);
			yh = int'(r.y_hi);
			v = longint'(r.value_in);
			a = longint'(r.alpha);
			want = '0;
			if (r.func == FN_POINT || r.func == FN_BOX || r.func == FN_OUTLINE) begin
				want.alpha_out_of_range = (r.alpha > ALPHA_ONE);
			end
			case (r.func)
				FN_POINT: reduce_at(xl, yl, op_reg, v, a);
				FN_BOX: begin
					lo = (yl < 0) ? 0 : yl;
					hi = (yh > eff_height() - 1) ? eff_height() - 1 : yh;
					for (int y = lo; y <= hi; y++) begin
						reduce_row(xl, xh, y, op_reg, v, a);
					end
				end
				FN_OUTLINE: begin
					reduce_row((xl < xh) ? xl : xh, (xl < xh) ? xh : xl, yl, r.outline_op, v, a);
					reduce_row((xl < xh) ? xl : xh, (xl < xh) ? xh : xl, yh, r.outline_op, v, a);
					reduce_col(xl, (yl < yh) ? yl : yh, (yl < yh) ? yh : yl, r.outline_op, v, a);
					reduce_col(xh, (yl < yh) ? yl : yh, (yl < yh) ? yh : yl, r.outline_op, v, a);
				end
				FN_READ: begin
					if (xl >= 0 && xl < eff_width() && yl >= 0 && yl < eff_height()) begin
						want.pixel_value = pixels[yl * MAX_WIDTH + xl];
					end
				end
				FN_CLEAR: begin
					fill = (op_reg == OP_MIN) ? STORE_MAX : ((op_reg == OP_MAX) ? STORE_MIN : '0);
					foreach (pixels[i]) begin
						pixels[i] = fill;
					end
				end
				default: ;
			endcase
			expected_pixels.push_back(want);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_pixels.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected response: pixel_value %0d alpha flag %0b",
						got.pixel_value, got.alpha_out_of_range);
				end
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel_value !== want.pixel_value
					|| got.alpha_out_of_range !== want.alpha_out_of_range) begin
				if (mismatches < 10) begin
					$display("mismatch: pixel expected %0d got %0d, flag expected %0b got %0b",
						want.pixel_value, got.pixel_value, want.alpha_out_of_range,
						got.alpha_out_of_range);
				end
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function int failures();
			return mismatches + expected_pixels.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	framebuffer_shadow board;
	bit quiet;
	int idle_cycles = 0;

	framebuffer_reduce_blend_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#4 clk = ~clk;
		end
	end

	// response side stalls in short bursts
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			board.check_result(rsp_data);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic req_t make_cmd(logic [FUNC_W-1:0] func, int xl, int xh, int yl, int yh,
			logic signed [STORE_W-1:0] v, int a, logic [OP_W-1:0] op);
		req_t r;
		r.func = func;
		r.x_lo = COORD_W'(xl);
		r.x_hi = COORD_W'(xh);
		r.y_lo = COORD_W'(yl);
		r.y_hi = COORD_W'(yh);
		r.value_in = v;
		r.alpha = ALPHA_W'(a);
		r.outline_op = op;
		return r;
	endfunction

	function automatic int pick_coord(int n);
		int span;
		span = ($urandom_range(0, 3) == 0 || n < 12) ? n : 12;
		return int'($urandom_range(0, span + 5)) - 3;
	endfunction

	function automatic req_t random_cmd(int w, int h);
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) r.func = FN_POINT;
		else if (pick < 55) r.func = FN_BOX;
		else if (pick < 70) r.func = FN_OUTLINE;
		else if (pick < 96) r.func = FN_READ;
		else r.func = FUNC_W'($urandom_range(5, 7));
		case ($urandom_range(0, 3))
			0: r.value_in = $urandom;
			1: r.value_in = int'($urandom_range(0, 1 << 20)) - (1 << 19);
			2: r.value_in = int'($urandom_range(0, 8 << 16)) - (4 << 16);
			default: begin
				case ($urandom_range(0, 3))
					0: r.value_in = STORE_MAX;
					1: r.value_in = STORE_MIN;
					2: r.value_in = '0;
					default: r.value_in = -1;
				endcase
			end
		endcase
		case ($urandom_range(0, 7))
			0: r.alpha = '0;
			1: r.alpha = ALPHA_ONE;
			2: r.alpha = '1;
			default: r.alpha = ALPHA_W'($urandom_range(0, 131071));
		endcase
		r.outline_op = OP_W'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) begin
			// wide random coordinates; a filled box keeps few rows
			r.x_lo = COORD_W'($urandom);
			r.x_hi = COORD_W'($urandom);
			r.y_lo = COORD_W'($urandom);
			r.y_hi = (r.func == FN_BOX)
				? r.y_lo + COORD_W'($urandom_range(0, 8)) - COORD_W'(1)
				: COORD_W'($urandom);
		end else begin
			r.x_lo = COORD_W'(pick_coord(w));
			r.y_lo = COORD_W'(pick_coord(h));
			r.x_hi = r.x_lo + COORD_W'($urandom_range(0, 6)) - COORD_W'(1);
			r.y_hi = r.y_lo + COORD_W'($urandom_range(0, 6)) - COORD_W'(1);
		end
		return r;
	endfunction

	task automatic send_cmd(req_t r);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do begin
			@(posedge clk);
		end while (req_stall);
		board.accept_command(r);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (board.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		board.write_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(int w, int h, logic [OP_W-1:0] op, int count, bit clear_first);
		wait_idle();
		write_register(CFG_WIDTH, CFG_DATA_W'(w));
		write_register(CFG_HEIGHT, CFG_DATA_W'(h));
		write_register(CFG_OP, CFG_DATA_W'(op));
		if (clear_first) begin
			send_cmd(make_cmd(FN_CLEAR, 0, 0, 0, 0, 0, 0, OP_MIN));
		end
		for (int i = 0; i < count; i++) begin
			send_cmd(random_cmd(board.eff_width(), board.eff_height()));
		end
	endtask

	initial begin
		board = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset config: 256 x 256, sum
		send_cmd(make_cmd(FN_CLEAR, 0, 0, 0, 0, 0, 0, OP_MIN));
		send_cmd(make_cmd(FN_READ, 0, 0, 0, 0, STORE_MAX, 131071, OP_SET));
		send_cmd(make_cmd(FN_POINT, 0, 0, 0, 0, STORE_MAX, 131071, OP_MIN));
		send_cmd(make_cmd(FN_POINT, 0, 0, 0, 0, STORE_MAX, 131071, OP_MIN));
		send_cmd(make_cmd(FN_READ, 0, 0, 0, 0, 0, 0, OP_MIN));
		send_cmd(make_cmd(FN_POINT, 255, 0, 255, 0, STORE_MIN, 65536, OP_MIN));
		send_cmd(make_cmd(FN_POINT, 255, 0, 255, 0, STORE_MIN, 65536, OP_MIN));
		send_cmd(make_cmd(FN_READ, 255, 0, 255, 0, 0, 0, OP_MIN));
		send_cmd(make_cmd(FN_POINT, 256, 0, 0, 0, 65536, 65536, OP_MIN));
		send_cmd(make_cmd(FN_POINT, -1, 0, -1, 0, 65536, 65536, OP_MIN));
		send_cmd(make_cmd(FN_READ, -32768, 0, 32767, 0, 0, 0, OP_MIN));
		send_cmd(make_cmd(FN_BOX, -32768, 32767, 3, 3, 65536, 65536, OP_MIN));
		send_cmd(make_cmd(FN_BOX, 10, 5, 3, 3, 65536, 65536, OP_MIN));
		send_cmd(make_cmd(FN_READ, 100, 0, 3, 0, 0, 0, OP_MIN));
		send_cmd(make_cmd(FN_OUTLINE, 32767, -32768, -32768, 32767, 0, 0, OP_SET));
		send_cmd(make_cmd(FN_OUTLINE, 5, 2, 1, 4, 3 << 16, 32768, OP_MAX));
		send_cmd(make_cmd(FN_OUTLINE, 2, 5, 4, 1, 1 << 16, 65536, OP_SUM));
		send_cmd(make_cmd(FN_READ, 2, 0, 1, 0, 0, 0, OP_MIN));
		send_cmd(make_cmd(FN_READ, 3, 0, 1, 0, 0, 0, OP_MIN));
		send_cmd(make_cmd(FN_READ, 3, 0, 3, 0, 0, 0, OP_MIN));
		send_cmd(make_cmd(3'd5, 1, 2, 3, 4, -1, 131071, OP_SET));
		send_cmd(make_cmd(3'd7, -1, -1, -1, -1, -1, 131071, OP_SET));
		send_cmd(make_cmd(FN_POINT, 7, 0, 7, 0, -65536, 65537, OP_MIN));
		send_cmd(make_cmd(FN_READ, 7, 0, 7, 0, 0, 0, OP_MIN));

		wait_idle();
		write_register(CFG_SPARE, '1);
		run_phase(1, 1, OP_MIN, 130, 1'b1);
		run_phase(256, 256, OP_MAX, 150, 1'b1);
		run_phase(16, 8, OP_SET, 130, 1'b1);
		run_phase(0, 300, OP_SUM, 40, 1'b0);
		run_phase(511, 1, OP_MIN, 100, 1'b0);
		quiet = 1'b1;
		run_phase(37, 23, OP_SUM, 150, 1'b1);
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (board.failures() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
